// ===== rtl/tmcw_pkg.sv =====
package tmcw_pkg;

  // Mode codes carried in the input transaction
  localparam logic [1:0] MODE_DRAW = 2'd0;
  localparam logic [1:0] MODE_FILL = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Palette component levels
  localparam logic [7:0] LVL_0 = 8'h00;
  localparam logic [7:0] LVL_L = 8'h55;
  localparam logic [7:0] LVL_M = 8'hAA;
  localparam logic [7:0] LVL_H = 8'hFF;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [3:0] FG_BOLD    = 4'h8;

  localparam int unsigned PAL_SIZE = 16;
  localparam int unsigned DIST_W   = 18;  // 3 * 255^2 fits in 18 bits
  localparam int unsigned CELL_W   = 16;

  // {red, green, blue} for each palette index
  localparam logic [23:0] PALETTE [PAL_SIZE] = '{
    {LVL_0, LVL_0, LVL_0}, {LVL_0, LVL_0, LVL_M}, {LVL_0, LVL_M, LVL_0}, {LVL_0, LVL_M, LVL_M},
    {LVL_M, LVL_0, LVL_0}, {LVL_M, LVL_0, LVL_M}, {LVL_M, LVL_L, LVL_0}, {LVL_M, LVL_M, LVL_M},
    {LVL_L, LVL_L, LVL_L}, {LVL_L, LVL_L, LVL_H}, {LVL_L, LVL_H, LVL_L}, {LVL_L, LVL_H, LVL_H},
    {LVL_H, LVL_L, LVL_L}, {LVL_H, LVL_L, LVL_H}, {LVL_H, LVL_H, LVL_L}, {LVL_H, LVL_H, LVL_H}
  };

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [11:0] col;
    logic signed [11:0] row;
    logic [7:0]         char_code;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               bold;
  } in_item_t;

  typedef struct packed {
    logic       in_bounds;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [3:0] color_index;
  } out_item_t;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

endpackage

// ===== rtl/text_mode_cell_writer_core.sv =====
// Channel   Dir  Handshake                Payload
// --------  ---  -----------------------  ---------------------------
// in        in   in_valid_i / in_ready_o  in_item_i  (tmcw_pkg::in_item_t)
// out       out  out_valid_o / out_ready_i out_item_o (tmcw_pkg::out_item_t)
//
// Each transaction is accepted in idle, which issues the cell read; the search then
// visits all 16 palette entries, one entry per cycle through a single distance unit;
// write-back forms the result and writes the cell back.
// After reset a clearing pass zeroes the screen memory, one cell per cycle, over all
// SCREEN_COLS*SCREEN_ROWS cells; in_ready_o stays low meanwhile.
// A full output register lets the next transaction be accepted and searched;
// the write-back step waits only while the previous result is still untaken.
module text_mode_cell_writer_core #(
  parameter int unsigned SCREEN_COLS = 80,
  parameter int unsigned SCREEN_ROWS = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmcw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmcw_pkg::out_item_t out_item_o
);
  import tmcw_pkg::*;

  localparam int unsigned CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned CW = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
  localparam int unsigned RW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

  // Sequencer states
  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_WRITE  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [3:0]        k_q, k_d;
  logic [DIST_W-1:0] min_dist_q, min_dist_d;
  logic [3:0]        best_idx_q, best_idx_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  // Latched transaction
  in_item_t          item_q;
  logic              inb_q;
  logic [AW-1:0]     addr_q;

  // Screen memory
  logic [CELL_W-1:0] cell_mem_q [CELL_COUNT];
  logic [CELL_W-1:0] rd_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              accept;
  logic              in_inb;
  logic [AW-1:0]     in_addr;
  logic [AW-1:0]     row_a, col_a;
  logic [23:0]       pal_rgb;
  logic [DIST_W-1:0] pal_dist;
  logic              is_read;
  logic [3:0]        idx;
  logic              load_out;
  out_item_t         res;
  logic [CELL_W-1:0] res_cell;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Bounds check and linear address of the incoming cell
  assign in_inb = !in_item_i.col[11] && ($unsigned(in_item_i.col) < 12'(SCREEN_COLS)) &&
                  !in_item_i.row[11] && ($unsigned(in_item_i.row) < 12'(SCREEN_ROWS));
  assign row_a   = AW'(in_item_i.row[RW-1:0]);
  assign col_a   = AW'(in_item_i.col[CW-1:0]);
  assign in_addr = AW'(row_a * AW'(SCREEN_COLS) + col_a);

  // One palette distance per cycle
  assign pal_rgb  = PALETTE[k_q];
  assign pal_dist = DIST_W'(sq_diff(item_q.red,   pal_rgb[23:16])) +
                    DIST_W'(sq_diff(item_q.green, pal_rgb[15:8])) +
                    DIST_W'(sq_diff(item_q.blue,  pal_rgb[7:0]));

  // Result formation from the search result and the cell read at accept
  assign is_read = (item_q.mode >= MODE_READ);
  assign idx     = is_read ? 4'd0 : best_idx_q;

  always_comb begin
    res             = '0;
    res.in_bounds   = inb_q;
    res.color_index = idx;
    if (inb_q) begin
      unique case (item_q.mode)
        MODE_DRAW: begin
          res.cell_char = item_q.char_code;
          res.cell_attr = {rd_q[15:12], idx | (item_q.bold ? FG_BOLD : 4'd0)};
        end
        MODE_FILL: begin
          res.cell_char = CHAR_SPACE;
          res.cell_attr = {idx, 4'd0};
        end
        default: begin
          // Read and the unused code both return the stored cell
          res.cell_char = rd_q[7:0];
          res.cell_attr = rd_q[15:8];
        end
      endcase
    end
  end

  assign res_cell = {res.cell_attr, res.cell_char};
  assign load_out = (state_q == S_WRITE) && (!out_valid_q || out_ready_i);

  // Single write port: clearing sweep or item write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = res_cell;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (load_out && inb_q && !is_read) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    min_dist_d  = min_dist_q;
    best_idx_d  = best_idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // Drop the output transaction once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(CELL_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          k_d         = 4'd0;
          min_dist_d  = '1;
          best_idx_d  = 4'd0;
          state_d     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // Strict compare keeps the lowest index on a tie
        if (pal_dist < min_dist_q) begin
          min_dist_d = pal_dist;
          best_idx_d = k_q;
        end
        k_d = k_q + 4'd1;
        if (k_q == 4'(PAL_SIZE - 1)) begin
          state_d = S_WRITE;
        end
      end
      default: begin
        // Hold here while the previous result is still waiting
        if (load_out) begin
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      min_dist_q  <= '1;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      min_dist_q  <= min_dist_d;
      best_idx_q  <= best_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      item_q <= in_item_i;
      inb_q  <= in_inb;
      addr_q <= in_addr;
    end
  end

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem_q[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_q <= cell_mem_q[in_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_accept_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SEARCH) && (k_q == 4'd0))
    else $error("accepted transaction did not start the palette search");

  a_search_ends_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) && (k_q == 4'(PAL_SIZE - 1)) |=> (state_q == S_WRITE))
    else $error("palette search did not hand over to write-back");

  a_result_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_WRITE))
    else $error("result appeared outside write-back");

  a_offscreen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.in_bounds |->
      (out_item_o.cell_char == 8'd0) && (out_item_o.cell_attr == 8'd0))
    else $error("off-screen result carries cell data");

  a_no_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) || (state_q == S_IDLE) |-> !mem_we)
    else $error("screen memory written outside clearing and write-back");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tmcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int RANDOM_OPS = 1600;
  // Clearing pass, per-transaction palette search and random stalls, taken many times over
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 40;

  // The fourth mode code is unused and acts as a read
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [7:0] LEVELS [4] = '{8'h00, 8'h55, 8'hAA, 8'hFF};

  // {red, green, blue} of the fixed colors
  localparam logic [23:0] COLOR_TABLE [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  in_item_t  pending_ops [$];
  out_item_t expected_cells [$];
  logic [15:0] screen_model [CELLS];

  out_item_t want;
  logic      run_q = 1'b0;
  logic      in_taken = 1'b0;
  int        cycle_count = 0;
  int        accepted_count = 0;
  int        err_count = 0;
  logic      calm;

  text_mode_cell_writer_core #(
    .SCREEN_COLS(COLS),
    .SCREEN_ROWS(ROWS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hold both sides busy without gaps over one stretch of the random part
  assign calm = (accepted_count >= 700) && (accepted_count < 1000);

  // Nearest fixed color by squared distance; strict compare keeps the lowest index on a tie
  function automatic logic [3:0] nearest_color(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    int min_sq;
    int sq_sum;
    int dr;
    int dg;
    int db;
    logic [3:0] best;
    best = '0;
    min_sq = 32'h7FFF_FFFF;
    for (int k = 0; k < 16; k++) begin
      dr = int'(r) - int'(COLOR_TABLE[k][23:16]);
      dg = int'(g) - int'(COLOR_TABLE[k][15:8]);
      db = int'(b) - int'(COLOR_TABLE[k][7:0]);
      sq_sum = dr * dr + dg * dg + db * db;
      if (sq_sum < min_sq) begin
        min_sq = sq_sum;
        best = 4'(k);
      end
    end
    return best;
  endfunction

  // Apply one transaction to the screen image and return the cell it reports
  function automatic out_item_t apply_cell_op(input in_item_t op);
    out_item_t  res;
    logic       is_read;
    logic [3:0] idx;
    logic [3:0] fg;
    logic [15:0] cur_cell;
    int         c;
    int         r;
    int         addr;
    res = '0;
    c = $signed(op.col);
    r = $signed(op.row);
    is_read = (op.mode == MODE_READ) || (op.mode == MODE_SPARE);
    idx = is_read ? 4'd0 : nearest_color(op.red, op.green, op.blue);
    res.color_index = idx;
    if (c >= 0 && c < COLS && r >= 0 && r < ROWS) begin
      addr = r * COLS + c;
      cur_cell = screen_model[addr];
      res.in_bounds = 1'b1;
      if (op.mode == MODE_DRAW) begin
        fg = idx | (op.bold ? FG_BOLD : 4'd0);
        res.cell_char = op.char_code;
        res.cell_attr = {cur_cell[15:12], fg};
        screen_model[addr] = {res.cell_attr, res.cell_char};
      end else if (op.mode == MODE_FILL) begin
        res.cell_char = CHAR_SPACE;
        res.cell_attr = {idx, 4'd0};
        screen_model[addr] = {res.cell_attr, res.cell_char};
      end else begin
        res.cell_char = cur_cell[7:0];
        res.cell_attr = cur_cell[15:8];
      end
    end
    return res;
  endfunction

  task automatic queue_op(input logic [1:0] mode, input int c, input int r,
                          input logic [7:0] ch, input logic [23:0] rgb, input logic bold);
    in_item_t op;
    op.mode = mode;
    op.col = 12'(c);
    op.row = 12'(r);
    op.char_code = ch;
    op.red = rgb[23:16];
    op.green = rgb[15:8];
    op.blue = rgb[7:0];
    op.bold = bold;
    pending_ops.push_back(op);
  endtask

  // Mix exact levels, near misses, tie midpoints and uniform values
  function automatic logic [7:0] pick_channel();
    logic [7:0] lv;
    lv = LEVELS[$urandom_range(0, 3)];
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return lv + 8'($urandom_range(0, 6)) - 8'd3;
      2: return (lv == 8'hFF) ? 8'h2A : lv + 8'h2A + 8'($urandom_range(0, 1));
      default: return lv;
    endcase
  endfunction

  // Driver: advance to the next transaction at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    if (run_q) begin
      if (!in_valid || in_taken) begin
        if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          in_valid <= 1'b1;
          in_item <= pending_ops.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // Monitor: check results, then record accepted inputs in order
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    run_q <= rst_ni;
    in_taken <= in_valid && in_ready_o;
    if (out_valid_o && out_ready) begin
      if (expected_cells.size() == 0) begin
        $error("result transaction with no expected cell pending");
        err_count++;
      end else begin
        want = expected_cells.pop_front();
        if (out_item_o.in_bounds !== want.in_bounds) begin
          $error("in_bounds: expected %0d, actual %0d", want.in_bounds, out_item_o.in_bounds);
          err_count++;
        end
        if (out_item_o.cell_char !== want.cell_char) begin
          $error("cell_char: expected %02h, actual %02h", want.cell_char, out_item_o.cell_char);
          err_count++;
        end
        if (out_item_o.cell_attr !== want.cell_attr) begin
          $error("cell_attr: expected %02h, actual %02h", want.cell_attr, out_item_o.cell_attr);
          err_count++;
        end
        if (out_item_o.color_index !== want.color_index) begin
          $error("color_index: expected %0d, actual %0d", want.color_index,
                 out_item_o.color_index);
          err_count++;
        end
      end
    end
    if (in_valid && in_ready_o) begin
      expected_cells.push_back(apply_cell_op(in_item));
      accepted_count <= accepted_count + 1;
    end
  end

  initial begin
    int sel;
    int c;
    int r;
    logic [1:0] mode;

    for (int i = 0; i < CELLS; i++) screen_model[i] = '0;

    // Directed: cleared store, corners, background kept, bounds, ties, back-to-back cell
    queue_op(MODE_READ, 5, 3, 8'h00, 24'h123456, 1'b1);
    queue_op(MODE_DRAW, 0, 0, 8'h41, 24'h0000AA, 1'b0);
    queue_op(MODE_DRAW, COLS - 1, ROWS - 1, 8'h5A, 24'hFFFFFF, 1'b1);
    queue_op(MODE_FILL, COLS - 1, 0, 8'h77, 24'hAA5500, 1'b1);
    queue_op(MODE_DRAW, COLS - 1, 0, 8'h78, 24'h555555, 1'b1);
    queue_op(MODE_READ, COLS - 1, 0, 8'hFF, 24'hFFFFFF, 1'b0);
    queue_op(MODE_SPARE, COLS - 1, ROWS - 1, 8'h00, 24'h00FF00, 1'b1);
    queue_op(MODE_DRAW, 0, ROWS - 1, 8'hFF, 24'h000000, 1'b1);
    queue_op(MODE_DRAW, 0, ROWS, 8'h31, 24'hFF55FF, 1'b0);
    queue_op(MODE_DRAW, -1, 0, 8'h32, 24'h55FFFF, 1'b1);
    queue_op(MODE_FILL, COLS, 5, 8'h33, 24'hAAAAAA, 1'b0);
    queue_op(MODE_READ, 2047, 2047, 8'h34, 24'hFFFF55, 1'b0);
    queue_op(MODE_DRAW, -2048, -2048, 8'h35, 24'h5555FF, 1'b1);
    queue_op(MODE_DRAW, 0, -1, 8'h36, 24'hFF5555, 1'b0);
    queue_op(MODE_DRAW, 1, 1, 8'h37, 24'h550000, 1'b0);
    queue_op(MODE_FILL, 1, 1, 8'h38, 24'h005500, 1'b1);
    queue_op(MODE_FILL, 3, 2, 8'h39, 24'hFF55FF, 1'b0);
    queue_op(MODE_DRAW, 3, 2, 8'h71, 24'h00AA00, 1'b0);
    queue_op(MODE_DRAW, 3, 2, 8'h72, 24'h00AA00, 1'b1);
    queue_op(MODE_READ, 3, 2, 8'h00, 24'h000000, 1'b0);
    queue_op(MODE_READ, 0, 0, 8'h00, 24'hFFFFFF, 1'b1);
    queue_op(MODE_DRAW, COLS - 1, ROWS - 1, 8'h00, 24'h7F7F7F, 1'b0);
    queue_op(MODE_FILL, 0, 0, 8'hFF, 24'hFFFFFF, 1'b1);
    queue_op(MODE_READ, 1, 1, 8'h00, 24'h000000, 1'b0);

    // Random: mostly on-screen traffic, a hot corner for read-modify-write hazards, edges
    for (int i = 0; i < RANDOM_OPS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) mode = MODE_DRAW;
      else if (sel < 65) mode = MODE_FILL;
      else if (sel < 95) mode = MODE_READ;
      else mode = MODE_SPARE;
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        c = $urandom_range(0, 3);
        r = $urandom_range(0, 1);
      end else if (sel < 75) begin
        c = $urandom_range(0, COLS - 1);
        r = $urandom_range(0, ROWS - 1);
      end else if (sel < 87) begin
        c = $urandom_range(0, COLS + 3) - 2;
        r = $urandom_range(0, ROWS + 3) - 2;
      end else begin
        c = $urandom_range(0, 4095) - 2048;
        r = $urandom_range(0, 4095) - 2048;
      end
      queue_op(mode, c, r, 8'($urandom_range(0, 255)),
               {pick_channel(), pick_channel(), pick_channel()}, 1'($urandom_range(0, 1)));
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every transaction to be taken and answered
    while ((pending_ops.size() != 0 || in_valid || expected_cells.size() != 0) &&
           cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
    end

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_mode_cell_writer_core verification failed");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (err_count == 0 && expected_cells.size() == 0) begin
        $display("text_mode_cell_writer_core verification clean");
      end else begin
        $display("text_mode_cell_writer_core verification failed");
      end
    end
    $finish;
  end

endmodule
